### src/bba_pkg.sv
// shared types, constants and search functions for the bitmap block allocator
// no dependencies

package bba_pkg;

	localparam int NUM_BLOCKS = 1024;   // multiple of WORD_W
	localparam int WORD_W     = 32;
	localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;
	localparam int ADDR_W     = $clog2(NUM_WORDS);
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int POS_W      = ADDR_W + BIT_W;
	localparam int BLK_W      = 16;
	localparam int CNT_W      = 11;
	localparam int STAT_W     = 2;
	localparam int M_TDATA_W  = 32;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_ALLOC = 2'd2,
		STAT_RANGE     = 2'd3
	} status_t;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		word_t             wdata;
	} ram_req_t;

	typedef struct packed {
		logic [BLK_W-1:0] granted;
		logic [CNT_W-1:0] free_count;
		status_t          status;
	} result_t;

	// lowest clear bit of a bitmap word
	function automatic logic [BIT_W-1:0] first_free_bit(word_t v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!v[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

	// lowest word that still has a clear bit
	function automatic logic [ADDR_W-1:0] first_free_word(logic [NUM_WORDS-1:0] full);
		logic [ADDR_W-1:0] idx;
		idx = '0;
		for (int i = NUM_WORDS - 1; i >= 0; i--) begin
			if (!full[i]) begin
				idx = ADDR_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

### src/bba_map_ram.sv
// bitmap word memory, one write and one registered read port per cycle
// depends on bba_pkg; rows never written read as all clear

module bba_map_ram (
	input  logic              clk,
	input  logic              arst_n,
	input  bba_pkg::ram_req_t req,
	output bba_pkg::word_t    rdata
);
	import bba_pkg::*;

	word_t                mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] row_valid_q;
	word_t                rdata_q;
	logic                 rvalid_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
		end else begin
			if (req.we) begin
				row_valid_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rvalid_q <= row_valid_q[req.raddr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

### src/bba_ctrl.sv
// request sequencer: read, modify and write back one bitmap word per request
// depends on bba_pkg and drives bba_map_ram

module bba_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  bba_pkg::action_t           req_action,
	input  logic [bba_pkg::BLK_W-1:0]  req_block,
	input  logic [bba_pkg::BLK_W-1:0]  base,
	output bba_pkg::ram_req_t          ram_req,
	input  bba_pkg::word_t             ram_rdata,
	output logic                       res_valid,
	input  logic                       res_ready,
	output bba_pkg::result_t           res
);
	import bba_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_READ, S_MODIFY, S_DONE} state_t;

	localparam logic [BLK_W:0] LIMIT = (BLK_W + 1)'(NUM_BLOCKS);

	state_t               state_q;
	action_t              action_q;
	logic [BLK_W-1:0]     block_q;
	logic [NUM_WORDS-1:0] word_full_q;
	logic [CNT_W-1:0]     count_q;
	result_t              result_q;

	logic [ADDR_W-1:0]    addr_s1;
	logic [BIT_W-1:0]     bit_s1;
	logic                 range_err_s1;
	logic                 none_free_s1;

	logic [BLK_W:0]       diff;
	logic [POS_W-1:0]     free_pos;
	logic [ADDR_W-1:0]    rd_addr;
	logic [BIT_W-1:0]     alloc_bit;
	word_t                alloc_word;
	word_t                free_word;
	logic [BLK_W-1:0]     grant_sum;

	assign diff     = {1'b0, block_q} - {1'b0, base};
	assign free_pos = diff[POS_W-1:0];
	assign rd_addr  = (action_q == ACT_ALLOC) ? first_free_word(word_full_q)
	                                          : free_pos[POS_W-1:BIT_W];

	assign alloc_bit  = first_free_bit(ram_rdata);
	assign alloc_word = ram_rdata | (word_t'(1) << alloc_bit);
	assign free_word  = ram_rdata & ~(word_t'(1) << bit_s1);
	assign grant_sum  = BLK_W'({addr_s1, alloc_bit}) + base;

	always_comb begin
		ram_req       = '0;
		ram_req.re    = (state_q == S_READ);
		ram_req.raddr = rd_addr;
		ram_req.waddr = addr_s1;
		if (state_q == S_MODIFY) begin
			if (action_q == ACT_ALLOC) begin
				ram_req.we    = !none_free_s1;
				ram_req.wdata = alloc_word;
			end else begin
				ram_req.we    = !range_err_s1 && ram_rdata[bit_s1];
				ram_req.wdata = free_word;
			end
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			word_full_q <= '0;
			count_q     <= CNT_W'(NUM_BLOCKS);
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_MODIFY;
				end
				S_MODIFY: begin
					state_q <= S_DONE;
					if (action_q == ACT_ALLOC) begin
						if (!none_free_s1) begin
							count_q              <= count_q - CNT_W'(1);
							word_full_q[addr_s1] <= &alloc_word;
						end
					end else if (!range_err_s1 && ram_rdata[bit_s1]) begin
						count_q              <= count_q + CNT_W'(1);
						word_full_q[addr_s1] <= 1'b0;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and per-stage payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			action_q <= req_action;
			block_q  <= req_block;
		end
		if (state_q == S_READ) begin
			addr_s1      <= rd_addr;
			bit_s1       <= free_pos[BIT_W-1:0];
			range_err_s1 <= (diff >= LIMIT);
			none_free_s1 <= &word_full_q;
		end
		if (state_q == S_MODIFY) begin
			if (action_q == ACT_ALLOC) begin
				if (none_free_s1) begin
					result_q.status     <= STAT_FULL;
					result_q.granted    <= '0;
					result_q.free_count <= count_q;
				end else begin
					result_q.status     <= STAT_OK;
					result_q.granted    <= grant_sum;
					result_q.free_count <= count_q - CNT_W'(1);
				end
			end else if (range_err_s1) begin
				result_q.status     <= STAT_RANGE;
				result_q.granted    <= '0;
				result_q.free_count <= count_q;
			end else if (!ram_rdata[bit_s1]) begin
				result_q.status     <= STAT_NOT_ALLOC;
				result_q.granted    <= '0;
				result_q.free_count <= count_q;
			end else begin
				result_q.status     <= STAT_OK;
				result_q.granted    <= '0;
				result_q.free_count <= count_q + CNT_W'(1);
			end
		end
	end

endmodule

### src/bitmap_block_allocator_unit.sv
// top level of the bitmap block allocator: stream ports, base register, output register
// depends on bba_pkg, bba_map_ram and bba_ctrl

// First-fit block allocator over a bitmap of 1024 data blocks. Each input beat is
// either an allocate (s_tuser = 0), which takes the lowest free block and returns
// its absolute number (bitmap position plus base_block, wrapped to 16 bits), or a
// free (s_tuser = 1) of the absolute block in s_tdata. Every beat yields exactly one
// result beat carrying the granted block, the free count after the request and a
// status: ok, full, block was not allocated, or block out of range. The bitmap sits
// in a 32 x 32-bit memory with a registered read port, and a per-word "full" flag
// in flip-flops points the allocate search at the right word. A request passes
// through accept, memory read, modify and write back, and hand-off to the output
// register. The next beat is accepted while a result waits in the output register.
// Rows of the memory carry valid bits cleared by reset, so there is no clearing pass
// and the block is ready right after reset. Write base_block only while idle.

module bitmap_block_allocator_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,    // base_block
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,        // [15:0] block_number
	input  logic [0:0]  s_tuser,        // [0] action
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,        // [15:0] granted_block, [26:16] free_count, zero above
	output logic [1:0]  m_tuser         // [1:0] status
);
	import bba_pkg::*;

	logic [BLK_W-1:0] base_q;
	ram_req_t         ram_req;
	word_t            ram_rdata;
	logic             res_valid;
	logic             res_ready;
	result_t          res;
	logic             out_valid_q;
	result_t          out_q;

	// base block register; the user must write it only while the unit is idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	bba_map_ram u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rdata  (ram_rdata)
	);

	bba_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (s_tvalid),
		.req_ready  (s_tready),
		.req_action (action_t'(s_tuser[0])),
		.req_block  (s_tdata),
		.base       (base_q),
		.ram_req    (ram_req),
		.ram_rdata  (ram_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// output register decouples the sequencer from a stalled consumer
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_TDATA_W - CNT_W - BLK_W)'(0), out_q.free_count, out_q.granted};
	assign m_tuser  = out_q.status;

	// a result handed over always shows up on the result port next cycle
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> m_tvalid)
		else $error("result lost between sequencer and output register");

	// an accepted request keeps the unit busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while previous one still in flight");

	// a full report means nothing is free and nothing was granted
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.status == STAT_FULL) |->
			(out_q.free_count == '0 && out_q.granted == '0))
		else $error("full status with free blocks or a grant");

	// free count can never exceed the bitmap size
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_q.free_count <= CNT_W'(NUM_BLOCKS)))
		else $error("free count above bitmap size");

endmodule

### bench/bba_alloc_checker.sv
`timescale 1ns / 1ps
// result checker for the bitmap block allocator: follows base_block writes and request beats,
// predicts every result beat and compares it with the result stream
// depends on bba_pkg

module bba_alloc_checker
	import bba_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          fail_count,
	output int          pending,
	output int          blocks_free
);

	bit               used_map [NUM_BLOCKS];
	int               free_left;
	logic [BLK_W-1:0] base_reg;
	result_t          alloc_results_q [$];
	int               errs;

	// first-fit allocate or release, updates the shadow bitmap
	function automatic result_t apply_request(action_t act, logic [BLK_W-1:0] blk);
		result_t r;
		int      pos;
		bit      found;
		r.granted = '0;
		r.status  = STAT_OK;
		pos       = 0;
		found     = 1'b0;
		if (act == ACT_ALLOC) begin
			for (int i = 0; i < NUM_BLOCKS; i++) begin
				if (!found && !used_map[i]) begin
					pos   = i;
					found = 1'b1;
				end
			end
			if (found) begin
				used_map[pos] = 1'b1;
				free_left--;
				r.granted = BLK_W'(pos + int'(base_reg));
			end else begin
				r.status = STAT_FULL;
			end
		end else if (blk < base_reg) begin
			r.status = STAT_RANGE;
		end else begin
			pos = int'(blk) - int'(base_reg);
			if (pos >= NUM_BLOCKS) begin
				r.status = STAT_RANGE;
			end else if (!used_map[pos]) begin
				r.status = STAT_NOT_ALLOC;
			end else begin
				used_map[pos] = 1'b0;
				free_left++;
			end
		end
		r.free_count = CNT_W'(free_left);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			foreach (used_map[i]) used_map[i] = 1'b0;
			free_left = NUM_BLOCKS;
			base_reg  = '0;
			alloc_results_q.delete();
			errs      = 0;
		end else begin
			if (cfg_wr_en) begin
				base_reg = cfg_wr_data;
			end
			// result beat first: it can never belong to a request taken on this edge
			if (m_tvalid && m_tready) begin
				if (alloc_results_q.size() == 0) begin
					errs++;
					if (errs <= 10) begin
						$display("%0t: result beat with none expected, tdata %h tuser %0d",
							$realtime, m_tdata, m_tuser);
					end
				end else begin
					want = alloc_results_q.pop_front();
					if (m_tdata[15:0] !== want.granted || m_tdata[26:16] !== want.free_count ||
					    m_tdata[31:27] !== 5'd0 || m_tuser !== want.status) begin
						errs++;
						if (errs <= 10) begin
							$display("%0t: mismatch granted exp %h act %h, free exp %0d act %0d, status exp %0d act %0d, pad act %h",
								$realtime, want.granted, m_tdata[15:0], want.free_count,
								m_tdata[26:16], want.status, m_tuser, m_tdata[31:27]);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				alloc_results_q.push_back(apply_request(action_t'(s_tuser[0]), s_tdata));
			end
		end
		fail_count  <= errs;
		pending     <= alloc_results_q.size();
		blocks_free <= free_left;
	end

endmodule

### bench/bitmap_block_allocator_unit_tb.sv
`timescale 1ns / 1ps
// testbench top for the bitmap block allocator: clock, reset, request and config stimulus,
// result-side stalls and the verdict; depends on bba_pkg, the allocator rtl and bba_alloc_checker

module bitmap_block_allocator_unit_tb;
	import bba_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;       // [15:0] block_number
	logic [0:0]  s_tuser;       // [0] action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;       // [15:0] granted_block, [26:16] free_count
	logic [1:0]  m_tuser;       // [1:0] status

	int fail_count;
	int pending;
	int blocks_free;

	// sender pacing: burst length left and the widest gap for the current phase
	int          burst_left;
	int          gap_hi;
	int          items_sent;
	logic [15:0] cur_base;

	// receiver pattern state, private to the receiver process but for long_hold, which the back-pressure process drives
	logic [4:0]  rx_phase = '0;
	logic [31:0] rx_mask  = '0;
	int          rx_level = 0;
	logic        long_hold = 1'b0;

	always #5 clk = ~clk;

	bitmap_block_allocator_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	bba_alloc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.fail_count  (fail_count),
		.pending     (pending),
		.blocks_free (blocks_free)
	);

	// receiver: whenever the 5-bit phase counter wraps, a new stall mask and a new stall level,
	// level 0 is a stretch with no stalls at all
	always @(posedge clk) begin
		if (rx_phase == 5'd0) begin
			rx_mask  = $urandom;
			rx_level = $urandom_range(0, 3);
		end
		rx_phase = rx_phase + 5'd1;
		if (long_hold) begin
			m_tready <= 1'b0;
		end else begin
			case (rx_level)
				0: begin
					m_tready <= 1'b1;
				end
				1: begin
					m_tready <= rx_mask[rx_phase];
				end
				2: begin
					// mostly stalled
					m_tready <= rx_mask[rx_phase] & rx_mask[5'd31 - rx_phase];
				end
				default: begin
					m_tready <= ($urandom_range(0, 7) != 0);
				end
			endcase
		end
	end

	// back-pressure: the receiver holds off for a long stretch while requests
	// keep coming, so the output register and then the input side fill up
	initial begin
		wait (items_sent >= 200);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (200) @(posedge clk);
		long_hold <= 1'b0;
		wait (items_sent >= 700);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (200) @(posedge clk);
		long_hold <= 1'b0;
	end

	// one request beat, with a random gap before each new burst
	task automatic put_req(action_t act, logic [15:0] blk);
		int gap;
		if (burst_left == 0) begin
			gap        = (gap_hi == 0) ? 0 : $urandom_range(0, gap_hi);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= blk;
		s_tuser  <= act;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// allocate, well-formed free near the base, or a free of any block number
	task automatic random_req(int alloc_pct, int pos_hi, int noise_pct);
		logic [15:0] blk;
		if ($urandom_range(0, 99) < alloc_pct) begin
			put_req(ACT_ALLOC, 16'($urandom));
		end else if ($urandom_range(0, 99) < noise_pct) begin
			put_req(ACT_FREE, 16'($urandom));
		end else begin
			blk = cur_base + 16'($urandom_range(0, pos_hi));
			put_req(ACT_FREE, blk);
		end
	endtask

	// drain: stop offering and wait until every result beat has come back
	task automatic settle();
		s_tvalid  <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// base_block write, only called while the block is drained
	task automatic set_base(logic [15:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		@(posedge clk);
		cur_base = v;
	endtask

	initial begin
		int waited;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = ACT_ALLOC;
		gap_hi      = 3;
		burst_left  = 0;
		items_sent  = 0;
		cur_base    = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, base 0 from reset
		put_req(ACT_FREE, 16'd0);           // free of a free block
		put_req(ACT_ALLOC, 16'hFFFF);       // block_number ignored on allocate
		put_req(ACT_ALLOC, 16'd0);
		put_req(ACT_ALLOC, 16'd0);
		put_req(ACT_FREE, 16'd1);
		put_req(ACT_FREE, 16'd1);           // second free of the same block
		put_req(ACT_ALLOC, 16'd0);          // first fit takes the hole again
		put_req(ACT_FREE, 16'd1024);        // just past the map
		put_req(ACT_FREE, 16'd1023);        // last position, never allocated
		put_req(ACT_FREE, 16'hFFFF);
		settle();

		// directed, high base
		set_base(16'hFFF0);
		put_req(ACT_ALLOC, 16'd0);
		put_req(ACT_FREE, 16'h0002);        // below the base
		put_req(ACT_FREE, 16'hFFF0);
		put_req(ACT_FREE, 16'hFFF0);
		put_req(ACT_ALLOC, 16'd0);
		settle();

		// directed, top base: grants above position 0 wrap past 65535
		set_base(16'hFFFF);
		put_req(ACT_ALLOC, 16'h5A5A);
		put_req(ACT_FREE, 16'hFFFF);
		put_req(ACT_ALLOC, 16'hA5A5);
		put_req(ACT_FREE, 16'hFFFE);
		settle();

		// mixed traffic on a sparse map
		gap_hi = 6;
		set_base(16'h0100);
		repeat (250) random_req(60, 80, 10);
		settle();

		// fill the map; the allocates after the fill loop see it full
		gap_hi = 2;
		set_base(16'h0000);
		while (blocks_free != 0) put_req(ACT_ALLOC, 16'($urandom));
		put_req(ACT_ALLOC, 16'h0000);
		put_req(ACT_ALLOC, 16'hFFFF);

		// full map, no sender idling
		gap_hi = 0;
		repeat (150) random_req(45, 1023, 10);
		settle();

		// random upper base, frees reach past the map
		gap_hi = 12;
		set_base(16'($urandom_range(16'h8000, 16'hFBFF)));
		repeat (100) random_req(50, 1100, 10);
		settle();

		// base where the upper half of the map wraps
		gap_hi = 4;
		set_base(16'hFE00);
		repeat (100) random_req(55, 1023, 5);

		s_tvalid <= 1'b0;
		waited    = 0;
		@(posedge clk);
		while (pending != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
